// ----- src/irs_pkg.sv -----
package irs_pkg;

	localparam int MASK_W = 8;
	localparam int OP_W = 3;
	localparam int CPU_W = 3;
	localparam int SWI_W = 32;
	localparam int ROUTE_W = 64;
	localparam int CFG_ADDR_W = 4;

	localparam logic [OP_W-1:0] OP_EDGE = 3'd0;
	localparam logic [OP_W-1:0] OP_ENABLE = 3'd1;
	localparam logic [OP_W-1:0] OP_RAISE = 3'd2;
	localparam logic [OP_W-1:0] OP_ACK = 3'd3;
	localparam logic [OP_W-1:0] OP_READ = 3'd4;

	localparam logic [CFG_ADDR_W-1:0] ADDR_ROUTE_MAP = 4'h0;

	// One per-cpu entry of the state memory.
	typedef struct packed {
		logic [SWI_W-1:0]  swi;
		logic [MASK_W-1:0] pending;
		logic [MASK_W-1:0] raw;
	} cpu_entry_t;

endpackage

// ----- src/irs_evt_if.sv -----
interface irs_evt_if;
	import irs_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [MASK_W-1:0] rise_lines;
	logic [MASK_W-1:0] fall_lines;
	logic [MASK_W-1:0] enable_value;
	logic [MASK_W-1:0] target_cpus;
	logic [CPU_W-1:0]  cpu_number;
	logic [SWI_W-1:0]  swi_bits;

	modport source (
		output valid, op, rise_lines, fall_lines, enable_value, target_cpus, cpu_number,
			swi_bits,
		input ready
	);
	modport sink (
		input valid, op, rise_lines, fall_lines, enable_value, target_cpus, cpu_number,
			swi_bits,
		output ready
	);

endinterface

// ----- src/irs_res_if.sv -----
interface irs_res_if;
	import irs_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] irq_assert;
	logic [MASK_W-1:0] irq_deassert;
	logic [MASK_W-1:0] wake_cpus;
	logic [MASK_W-1:0] masked_status;
	logic [MASK_W-1:0] enable_readback;

	modport source (
		output valid, irq_assert, irq_deassert, wake_cpus, masked_status, enable_readback,
		input ready
	);
	modport sink (
		input valid, irq_assert, irq_deassert, wake_cpus, masked_status, enable_readback,
		output ready
	);

endinterface

// ----- src/interrupt_router_with_swi_top.sv -----
// Interrupt router with software interrupts. Each transfer on evt carries one operation
// (line edges, enable write, software interrupt raise or acknowledge, or a read) and
// produces exactly one transfer on res with the irq assert, deassert and wakeup masks
// for the cpus and the resulting masked line status and enable mask. The route map is
// a 64-bit register on the APB port at address 0, byte i holding the cpu mask of line i;
// write it only while the block is idle. The per-cpu raw, pending and software interrupt
// state lives in one small synchronous memory that the engine walks one cpu entry per
// cycle, reading one entry and writing back the previous one. An item passes through the
// reads of all NUM_CPUS entries, the write back of the last entry, and a final state
// that folds the global line state into the result register. The final state waits
// while the output register still holds a result not yet taken. The input is ready
// again once the result is loaded, so a new item is taken even while that result still
// waits in the output register. The memory needs no clearing pass: one valid bit per
// entry, cleared by reset, makes an entry never written read as all zeros.
module interrupt_router_with_swi_top #(
	parameter int NUM_LINES = 8,
	parameter int NUM_CPUS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [irs_pkg::ROUTE_W-1:0]    pwdata,
	output logic [irs_pkg::ROUTE_W-1:0]    prdata,
	output logic                           pready,
	irs_evt_if.sink                        evt,
	irs_res_if.source                      res
);
	import irs_pkg::*;

	// Route map to engine: user changes it only while no item is in flight (not enforced).
	logic [ROUTE_W-1:0] route_map;

	irs_apb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.route_map (route_map)
	);

	// The engine owns the cpu state memory, the global line registers and the
	// result register that decouples the result transfer from the next item.
	irs_engine #(
		.NUM_LINES (NUM_LINES),
		.NUM_CPUS  (NUM_CPUS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.route_map (route_map),
		.evt       (evt),
		.res       (res)
	);

endmodule

// ----- src/irs_apb_cfg.sv -----
module irs_apb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [irs_pkg::ROUTE_W-1:0]    pwdata,
	output logic [irs_pkg::ROUTE_W-1:0]    prdata,
	output logic                           pready,
	output logic [irs_pkg::ROUTE_W-1:0]    route_map
);
	import irs_pkg::*;

	logic [ROUTE_W-1:0] route_map_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_map_q <= '0;
		end else if (wr_en && paddr == ADDR_ROUTE_MAP) begin
			route_map_q <= pwdata;
		end
	end

	assign prdata = (paddr == ADDR_ROUTE_MAP) ? route_map_q : '0;
	assign route_map = route_map_q;

endmodule

// ----- src/irs_engine.sv -----
module irs_engine #(
	parameter int NUM_LINES = 8,
	parameter int NUM_CPUS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [irs_pkg::ROUTE_W-1:0] route_map,
	irs_evt_if.sink                     evt,
	irs_res_if.source                   res
);
	import irs_pkg::*;

	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int CNTW = $clog2(NUM_CPUS + 1);
	localparam logic [MASK_W-1:0] LINE_MASK = MASK_W'((9'd1 << NUM_LINES) - 9'd1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		cpu_entry_t entry;
		logic       up;
		logic       down;
		logic       wake;
	} cpu_res_t;

	// Per-cpu read-modify-write step for one item.
	function automatic cpu_res_t cpu_step(
		input cpu_entry_t        e,
		input logic [OP_W-1:0]   op,
		input logic [MASK_W-1:0] rise,
		input logic [MASK_W-1:0] fall,
		input logic [MASK_W-1:0] en,
		input logic [MASK_W-1:0] new_en,
		input logic [MASK_W-1:0] col,
		input logic              tgt_hit,
		input logic              ack_hit,
		input logic [SWI_W-1:0]  bits
	);
		cpu_res_t          r;
		logic [MASK_W-1:0] raw;
		logic [MASK_W-1:0] pend;
		logic [SWI_W-1:0]  swi;
		logic              up;
		logic              down;
		r = '0;
		raw = e.raw;
		pend = e.pending;
		swi = e.swi;
		up = 1'b0;
		down = 1'b0;
		unique case (op)
			OP_EDGE: begin
				for (int i = 0; i < MASK_W; i++) begin
					if (rise[i] && col[i]) begin
						raw[i] = 1'b1;
						if (en[i]) begin
							if (pend == '0) up = 1'b1;
							pend[i] = 1'b1;
						end
					end else if (fall[i] && col[i]) begin
						raw[i] = 1'b0;
						if (en[i]) begin
							pend[i] = 1'b0;
							if (pend == '0) down = 1'b1;
						end
					end
				end
				if (swi == '0) begin
					r.up = up;
					r.wake = up;
					r.down = !up && down;
				end
			end
			OP_ENABLE: begin
				if (swi == '0) begin
					r.up = (pend == '0) && ((raw & new_en) != '0);
					r.down = (pend != '0) && ((raw & new_en) == '0);
				end
				pend = raw & new_en;
			end
			OP_RAISE: begin
				if (tgt_hit) begin
					swi = swi | bits;
					if (pend == '0) begin
						r.up = 1'b1;
						r.wake = 1'b1;
					end
				end
			end
			OP_ACK: begin
				if (ack_hit && swi != '0) begin
					swi = swi & ~bits;
					if (pend == '0 && swi == '0) r.down = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.entry.raw = raw;
		r.entry.pending = pend;
		r.entry.swi = swi;
		return r;
	endfunction

	state_t            state_q;
	logic [CNTW-1:0]   rd_cnt_q;
	logic              rd_valid_s1;
	logic [CW-1:0]     idx_s1;
	logic              vld_s1;
	cpu_entry_t        rdata_s1;
	logic [NUM_CPUS-1:0] vld_q;

	logic [OP_W-1:0]   op_q;
	logic [MASK_W-1:0] rise_q;
	logic [MASK_W-1:0] fall_q;
	logic [MASK_W-1:0] new_en_q;
	logic [MASK_W-1:0] tgt_q;
	logic [CPU_W-1:0]  cpu_q;
	logic [SWI_W-1:0]  bits_q;

	logic [MASK_W-1:0] line_raw_q;
	logic [MASK_W-1:0] line_en_q;
	logic [MASK_W-1:0] up_acc_q;
	logic [MASK_W-1:0] down_acc_q;
	logic [MASK_W-1:0] wake_acc_q;

	logic              out_valid_q;
	logic [MASK_W-1:0] out_assert_q;
	logic [MASK_W-1:0] out_deassert_q;
	logic [MASK_W-1:0] out_wake_q;
	logic [MASK_W-1:0] out_status_q;
	logic [MASK_W-1:0] out_en_q;

	cpu_entry_t        mem [NUM_CPUS];

	logic              accept;
	logic              rd_en;
	logic              out_free;
	logic [CPU_W-1:0]  cpu_s1;
	logic [MASK_W-1:0] col;
	cpu_entry_t        cur;
	cpu_res_t          step;
	logic [MASK_W-1:0] cpu_bit;
	logic [MASK_W-1:0] raw_next;
	logic [MASK_W-1:0] en_next;

	assign evt.ready = (state_q == ST_IDLE);
	assign accept = evt.valid && evt.ready;
	assign rd_en = (state_q == ST_RUN) && (rd_cnt_q < CNTW'(NUM_CPUS));
	assign out_free = !out_valid_q || res.ready;

	assign cpu_s1 = CPU_W'(idx_s1);
	assign cpu_bit = MASK_W'(1) << cpu_s1;
	assign cur = vld_s1 ? rdata_s1 : '0;

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			col[i] = route_map[6'(8 * i) + 6'(cpu_s1)];
		end
	end

	assign step = cpu_step(cur, op_q, rise_q, fall_q, line_en_q, new_en_q, col,
		tgt_q[cpu_s1], cpu_q == cpu_s1, bits_q);

	assign raw_next = (op_q == OP_EDGE) ? ((line_raw_q | rise_q) & ~(fall_q & ~rise_q))
		: line_raw_q;
	assign en_next = (op_q == OP_ENABLE) ? new_en_q : line_en_q;

	// State memory: registered read, write back from the update stage.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_cnt_q[CW-1:0]];
		end
		if (rd_valid_s1) begin
			mem[idx_s1] <= step.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= evt.op;
			rise_q <= evt.rise_lines & LINE_MASK;
			fall_q <= evt.fall_lines & LINE_MASK;
			new_en_q <= evt.enable_value;
			tgt_q <= evt.target_cpus;
			cpu_q <= evt.cpu_number;
			bits_q <= evt.swi_bits;
		end
		if (rd_en) begin
			idx_s1 <= rd_cnt_q[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_cnt_q <= '0;
			rd_valid_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_q <= '0;
			line_raw_q <= '0;
			line_en_q <= '0;
			up_acc_q <= '0;
			down_acc_q <= '0;
			wake_acc_q <= '0;
			out_valid_q <= 1'b0;
			out_assert_q <= '0;
			out_deassert_q <= '0;
			out_wake_q <= '0;
			out_status_q <= '0;
			out_en_q <= '0;
		end else begin
			// In the final state the result register is reloaded instead.
			if (out_valid_q && res.ready && state_q != ST_FIN) out_valid_q <= 1'b0;
			rd_valid_s1 <= rd_en;
			if (rd_en) begin
				vld_s1 <= vld_q[rd_cnt_q[CW-1:0]];
				rd_cnt_q <= rd_cnt_q + CNTW'(1);
			end
			if (rd_valid_s1) begin
				vld_q[idx_s1] <= 1'b1;
				if (step.up) up_acc_q <= up_acc_q | cpu_bit;
				if (step.down) down_acc_q <= down_acc_q | cpu_bit;
				if (step.wake) wake_acc_q <= wake_acc_q | cpu_bit;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						up_acc_q <= '0;
						down_acc_q <= '0;
						wake_acc_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_valid_s1 && idx_s1 == CW'(NUM_CPUS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						line_raw_q <= raw_next;
						line_en_q <= en_next;
						out_valid_q <= 1'b1;
						out_assert_q <= up_acc_q;
						out_deassert_q <= down_acc_q;
						out_wake_q <= wake_acc_q;
						out_status_q <= raw_next & en_next;
						out_en_q <= en_next;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.irq_assert = out_assert_q;
	assign res.irq_deassert = out_deassert_q;
	assign res.wake_cpus = out_wake_q;
	assign res.masked_status = out_status_q;
	assign res.enable_readback = out_en_q;

endmodule

// ----- tb/sv/irs_tb_pkg.sv -----
`timescale 1ns / 100ps

package irs_tb_pkg;
	import irs_pkg::*;

	localparam int LINE_COUNT = 8;
	localparam int CPU_COUNT = 8;

	// Op codes the block does not define; they must act as a read.
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [MASK_W-1:0] rise_lines;
		logic [MASK_W-1:0] fall_lines;
		logic [MASK_W-1:0] enable_value;
		logic [MASK_W-1:0] target_cpus;
		logic [CPU_W-1:0]  cpu_number;
		logic [SWI_W-1:0]  swi_bits;
	} router_event_t;

	typedef struct packed {
		logic [MASK_W-1:0] irq_assert;
		logic [MASK_W-1:0] irq_deassert;
		logic [MASK_W-1:0] wake_cpus;
		logic [MASK_W-1:0] masked_status;
		logic [MASK_W-1:0] enable_readback;
	} router_outcome_t;

	// Tracks the router state, works out the outcome of every accepted event and
	// matches the outcomes the block returns against them in order.
	class irq_router_tracker;
		logic [ROUTE_W-1:0] cpu_routes;
		logic [MASK_W-1:0]  line_level;
		logic [MASK_W-1:0]  enabled_lines;
		logic [MASK_W-1:0]  cpu_level[CPU_COUNT];
		logic [MASK_W-1:0]  cpu_active[CPU_COUNT];
		logic [SWI_W-1:0]   cpu_soft[CPU_COUNT];
		router_outcome_t    outcomes_due[$];
		int                 mismatches;
		int                 op_seen[8];
		int                 asserts_seen;
		int                 deasserts_seen;
		int                 wakes_seen;

		function new();
			cpu_routes = '0;
			line_level = '0;
			enabled_lines = '0;
			for (int c = 0; c < CPU_COUNT; c++) begin
				cpu_level[c] = '0;
				cpu_active[c] = '0;
				cpu_soft[c] = '0;
			end
			mismatches = 0;
			asserts_seen = 0;
			deasserts_seen = 0;
			wakes_seen = 0;
			for (int k = 0; k < 8; k++)
				op_seen[k] = 0;
		endfunction

		function void set_routes(logic [ROUTE_W-1:0] value);
			cpu_routes = value;
		endfunction

		function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
		endfunction

		function void compare_field(string what, logic [63:0] want, logic [63:0] got);
			if (got !== want)
				note_mismatch(what, want, got);
		endfunction

		function void take_event(router_event_t ev);
			router_outcome_t o;
			logic [MASK_W-1:0] lb;
			logic [MASK_W-1:0] routes;
			logic [MASK_W-1:0] gained;
			logic [MASK_W-1:0] emptied;
			bit hit;
			o = '0;
			gained = '0;
			emptied = '0;
			op_seen[ev.op]++;
			case (ev.op)
				OP_EDGE: begin
					// Lines are walked from line 0 up; a rise shadows a fall on the same line.
					for (int ln = 0; ln < LINE_COUNT; ln++) begin
						lb = '0;
						lb[ln] = 1'b1;
						routes = cpu_routes[8*ln +: 8];
						if (ev.rise_lines[ln]) begin
							line_level |= lb;
							for (int c = 0; c < CPU_COUNT; c++) begin
								if (routes[c]) begin
									cpu_level[c] |= lb;
									if (enabled_lines[ln]) begin
										if (cpu_active[c] == '0)
											gained[c] = 1'b1;
										cpu_active[c] |= lb;
									end
								end
							end
						end else if (ev.fall_lines[ln]) begin
							line_level &= ~lb;
							for (int c = 0; c < CPU_COUNT; c++) begin
								if (routes[c]) begin
									cpu_level[c] &= ~lb;
									if (enabled_lines[ln]) begin
										cpu_active[c] &= ~lb;
										if (cpu_active[c] == '0)
											emptied[c] = 1'b1;
									end
								end
							end
						end
					end
					for (int c = 0; c < CPU_COUNT; c++) begin
						if (cpu_soft[c] == '0) begin
							if (gained[c]) begin
								o.irq_assert[c] = 1'b1;
								o.wake_cpus[c] = 1'b1;
							end else if (emptied[c]) begin
								o.irq_deassert[c] = 1'b1;
							end
						end
					end
				end
				OP_ENABLE: begin
					for (int c = 0; c < CPU_COUNT; c++) begin
						hit = (cpu_level[c] & ev.enable_value) != '0;
						if (cpu_soft[c] == '0) begin
							if (cpu_active[c] == '0 && hit)
								o.irq_assert[c] = 1'b1;
							else if (cpu_active[c] != '0 && !hit)
								o.irq_deassert[c] = 1'b1;
						end
						cpu_active[c] = cpu_level[c] & ev.enable_value;
					end
					enabled_lines = ev.enable_value;
				end
				OP_RAISE: begin
					for (int c = 0; c < CPU_COUNT; c++) begin
						if (ev.target_cpus[c]) begin
							cpu_soft[c] |= ev.swi_bits;
							if (cpu_active[c] == '0) begin
								o.irq_assert[c] = 1'b1;
								o.wake_cpus[c] = 1'b1;
							end
						end
					end
				end
				OP_ACK: begin
					if (ev.cpu_number < CPU_COUNT && cpu_soft[ev.cpu_number] != '0) begin
						cpu_soft[ev.cpu_number] &= ~ev.swi_bits;
						if (cpu_active[ev.cpu_number] == '0 && cpu_soft[ev.cpu_number] == '0)
							o.irq_deassert[ev.cpu_number] = 1'b1;
					end
				end
				default: begin
				end
			endcase
			o.masked_status = line_level & enabled_lines;
			o.enable_readback = enabled_lines;
			outcomes_due.push_back(o);
		endfunction

		function void match_outcome(router_outcome_t got);
			router_outcome_t want;
			if (outcomes_due.size() == 0) begin
				note_mismatch("outcome with none due", '0, 64'(got));
				return;
			end
			want = outcomes_due.pop_front();
			compare_field("irq_assert", 64'(want.irq_assert), 64'(got.irq_assert));
			compare_field("irq_deassert", 64'(want.irq_deassert), 64'(got.irq_deassert));
			compare_field("wake_cpus", 64'(want.wake_cpus), 64'(got.wake_cpus));
			compare_field("masked_status", 64'(want.masked_status), 64'(got.masked_status));
			compare_field("enable_readback", 64'(want.enable_readback),
				64'(got.enable_readback));
			asserts_seen += $countones(want.irq_assert);
			deasserts_seen += $countones(want.irq_deassert);
			wakes_seen += $countones(want.wake_cpus);
		endfunction
	endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

// Testbench for the interrupt router. Every event transfer is predicted by a
// tracker that keeps its own copy of the line, enable, per-cpu and software
// interrupt state; each outcome transfer is matched field by field against the
// oldest prediction. The route map is rewritten between phases while the block
// is idle, and the sender and receiver both idle at random.
module testbench;
	import irs_pkg::*;
	import irs_tb_pkg::*;

	// Quiet cycles (no transfer on either channel) tolerated before giving up.
	// The limit leaves a wide margin over the slowest legal stretch, a receiver
	// stall or a phase change.
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 325;
	localparam logic [ROUTE_W-1:0] RING_ROUTES = 64'h81C0_6030_180C_0603;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [ROUTE_W-1:0] pwdata;
	logic [ROUTE_W-1:0] prdata;
	logic pready;
	int quiet_cycles = 0;
	int route_writes = 0;

	irq_router_tracker tracker;

	irs_evt_if evt();
	irs_res_if res();

	interrupt_router_with_swi_top #(
		.NUM_LINES(LINE_COUNT),
		.NUM_CPUS(CPU_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.evt(evt),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Outcome monitor and watchdog. Values are sampled as they stood just before
	// the edge, so a transfer is seen exactly at the edge that completes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid === 1'b1 && res.ready === 1'b1)
				tracker.match_outcome('{
					irq_assert: res.irq_assert,
					irq_deassert: res.irq_deassert,
					wake_cpus: res.wake_cpus,
					masked_status: res.masked_status,
					enable_readback: res.enable_readback
				});
			if ((evt.valid === 1'b1 && evt.ready === 1'b1) ||
					(res.valid === 1'b1 && res.ready === 1'b1))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d outcomes still due.",
					QUIET_LIMIT, tracker.outcomes_due.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// The receiver stalls on a pattern of its own: it picks a mode for a random
	// span of cycles, from always ready to ready only one cycle in four, or a
	// rotating bit pattern.
	initial begin
		int mode;
		int span;
		logic [7:0] pattern;
		res.ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			pattern = 8'($urandom) | 8'h01;
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: res.ready <= 1'b1;
					1: res.ready <= 1'($urandom_range(0, 1));
					2: res.ready <= ($urandom_range(0, 3) == 0);
					default: begin
						res.ready <= pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
			end
		end
	end

	function automatic router_event_t make_event(logic [OP_W-1:0] op, logic [MASK_W-1:0] rise,
			logic [MASK_W-1:0] fall, logic [MASK_W-1:0] en, logic [MASK_W-1:0] targets,
			logic [CPU_W-1:0] cpu, logic [SWI_W-1:0] bits);
		return '{op: op, rise_lines: rise, fall_lines: fall, enable_value: en,
			target_cpus: targets, cpu_number: cpu, swi_bits: bits};
	endfunction

	// Random events. Software interrupts are raised rarely and acknowledged
	// often, mostly with every bit, so that cpus keep coming out of suppression
	// and the line edge and enable paths get to drive the irq lines. Edge masks
	// are often sparse so that single-line rises and falls dominate.
	function automatic router_event_t random_event();
		router_event_t ev;
		int pick;
		ev = make_event(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			3'($urandom), $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			ev.op = OP_EDGE;
			if ($urandom_range(0, 2) != 0) begin
				ev.rise_lines = 8'($urandom & $urandom & $urandom);
				ev.fall_lines = 8'($urandom & $urandom & $urandom);
			end
		end else if (pick < 55) begin
			ev.op = OP_ENABLE;
			if ($urandom_range(0, 3) == 0)
				ev.enable_value = '1;
		end else if (pick < 63) begin
			ev.op = OP_RAISE;
			if ($urandom_range(0, 1) == 0)
				ev.swi_bits = 32'd1 << $urandom_range(0, 31);
		end else if (pick < 85) begin
			ev.op = OP_ACK;
			case ($urandom_range(0, 3))
				0, 1: ev.swi_bits = '1;
				2: ev.swi_bits = 32'd1 << $urandom_range(0, 31);
				default: begin
				end
			endcase
		end else begin
			case ($urandom_range(0, 3))
				0: ev.op = OP_READ;
				1: ev.op = OP_SPARE_A;
				2: ev.op = OP_SPARE_B;
				default: ev.op = OP_SPARE_C;
			endcase
		end
		return ev;
	endfunction

	// Presents one event and returns at the edge that completes its transfer.
	// Valid is left high so that a following event keeps it asserted.
	task automatic send_event(input router_event_t ev);
		evt.valid <= 1'b1;
		evt.op <= ev.op;
		evt.rise_lines <= ev.rise_lines;
		evt.fall_lines <= ev.fall_lines;
		evt.enable_value <= ev.enable_value;
		evt.target_cpus <= ev.target_cpus;
		evt.cpu_number <= ev.cpu_number;
		evt.swi_bits <= ev.swi_bits;
		@(posedge clk);
		while (evt.ready !== 1'b1)
			@(posedge clk);
		tracker.take_event(ev);
	endtask

	// Waits for every predicted outcome, then lets the block settle.
	task automatic drain();
		while (tracker.outcomes_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Writes the route map with a setup and an access cycle, then reads it back.
	task automatic write_routes(input logic [ROUTE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_ROUTE_MAP;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		tracker.set_routes(value);
		route_writes++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		tracker.compare_field("route_map readback", value, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sends random events in bursts of random length. Between bursts the
	// sender may idle for a random gap, and now and then it holds off until
	// every outcome already due has come back.
	task automatic run_phase(input int count, input bit with_gaps);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_event(random_event());
				left--;
			end
			if ($urandom_range(0, 39) == 0) begin
				evt.valid <= 1'b0;
				@(posedge clk);
				while (tracker.outcomes_due.size() != 0)
					@(posedge clk);
			end else if (with_gaps) begin
				gap = $urandom_range(0, 15);
				if (gap > 0) begin
					evt.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		evt.valid <= 1'b0;
	endtask

	initial begin
		logic [ROUTE_W-1:0] routes;
		tracker = new();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		evt.valid <= 1'b0;
		evt.op <= OP_READ;
		evt.rise_lines <= '0;
		evt.fall_lines <= '0;
		evt.enable_value <= '0;
		evt.target_cpus <= '0;
		evt.cpu_number <= '0;
		evt.swi_bits <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Each line routes to its own cpu and the next one, so
		// one line touches two cpus and neighboring lines share a cpu.
		write_routes(RING_ROUTES);
		send_event(make_event(OP_READ, '0, '0, '0, '0, '0, '0));
		// Lines rise while nothing is enabled, then enabling them asserts every cpu.
		send_event(make_event(OP_EDGE, '1, '0, '0, '0, '0, '0));
		send_event(make_event(OP_ENABLE, '0, '0, '1, '0, '0, '0));
		send_event(make_event(OP_EDGE, '0, '1, '0, '0, '0, '0));
		// Rise and fall on the same line: the rise is applied.
		send_event(make_event(OP_EDGE, 8'h01, 8'h01, '0, '0, '0, '0));
		// Cpu 1 loses line 0 and gains line 1 in one event: the assertion wins.
		send_event(make_event(OP_EDGE, 8'h02, 8'h01, '0, '0, '0, '0));
		// Software interrupts on every cpu, then edges that they suppress.
		send_event(make_event(OP_RAISE, '0, '0, '0, '1, '0, '1));
		send_event(make_event(OP_EDGE, '1, '0, '0, '0, '0, '0));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd3, 32'h0000_FFFF));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd3, 32'hFFFF_0000));
		send_event(make_event(OP_EDGE, '0, '1, '0, '0, '0, '0));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd5, '1));
		// Acknowledge with no software interrupt pending changes nothing.
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd5, '1));
		send_event(make_event(OP_RAISE, '0, '0, '0, 8'h20, '0, 32'h0000_0001));
		send_event(make_event(OP_EDGE, 8'h10, '0, '0, '0, '0, '0));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd4, '1));
		// Raise to a cpu that already has enabled interrupts: bits only.
		send_event(make_event(OP_RAISE, '0, '0, '0, 8'h10, '0, 32'h8000_0000));
		send_event(make_event(OP_SPARE_A, '1, '1, '1, '1, '1, '1));
		send_event(make_event(OP_SPARE_B, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 3'd2, 32'h1234_5678));
		send_event(make_event(OP_SPARE_C, '0, '0, '0, '0, '0, '0));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd7, '0));
		send_event(make_event(OP_ACK, '0, '0, '0, '0, 3'd0, '1));
		send_event(make_event(OP_ENABLE, '0, '0, '0, '0, '0, '0));
		send_event(make_event(OP_ENABLE, '0, '0, 8'hAA, '0, '0, '0));
		send_event(make_event(OP_EDGE, 8'h55, 8'hAA, '0, '0, '0, '0));
		evt.valid <= 1'b0;

		// Random phases, each under its own route map: none routed, all routed,
		// one cpu per line, and random maps. One phase runs without sender gaps.
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: routes = '0;
				1: routes = '1;
				2: routes = 64'h8040_2010_0804_0201;
				3: routes = {$urandom & $urandom, $urandom & $urandom};
				default: routes = {$urandom, $urandom};
			endcase
			write_routes(routes);
			run_phase(PHASE_ITEMS, phase != 2);
		end
		drain();

		$display("Sent %0d edge, %0d enable, %0d raise, %0d acknowledge and %0d read-like events",
			tracker.op_seen[OP_EDGE], tracker.op_seen[OP_ENABLE], tracker.op_seen[OP_RAISE],
			tracker.op_seen[OP_ACK], tracker.op_seen[OP_READ] + tracker.op_seen[OP_SPARE_A] +
			tracker.op_seen[OP_SPARE_B] + tracker.op_seen[OP_SPARE_C]);
		$display("under %0d route maps; %0d irq raises, %0d drops, %0d wakeups, %0d mismatches.",
			route_writes, tracker.asserts_seen, tracker.deasserts_seen, tracker.wakes_seen,
			tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
